>>> sv/rrep_pkg.sv
// Package with the shared types and constants of the receive ring entry parser.
`timescale 1ns / 1ps

package rrep_pkg;

  localparam int RING_BYTES  = 8192;
  localparam int PTR_W       = $clog2(RING_BYTES);
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_AW       = $clog2(CQ_DEPTH);
  localparam int CQ_CW       = $clog2(CQ_DEPTH + 1);
  localparam int RQ_DEPTH    = 4;
  localparam int RQ_AW       = $clog2(RQ_DEPTH);
  localparam int RQ_CW       = $clog2(RQ_DEPTH + 1);

  localparam logic [15:0] PENDING_LEN = 16'hfff0;
  localparam int          MIN_FRAME   = 14;
  localparam int          CRC_BYTES   = 4;
  localparam int          CAPR_OFFSET = 16;
  localparam logic [12:0] MAX_FRAME_RESET = 13'd1514;

  localparam logic REG_ENABLED       = 1'b0;
  localparam logic REG_MAX_FRAME_LEN = 1'b1;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_PENDING = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic [12:0] flen;
    logic [13:0] span;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [12:0] frame_length;
    logic [12:0] next_read_ptr;
    logic [15:0] capr_value;
    logic [31:0] packet_count;
    logic [47:0] byte_count;
    logic [31:0] error_count;
  } res_t;

endpackage

>>> sv/rrep_front.sv
// Front part: header parsing, byte classification and the command queue.
`timescale 1ns / 1ps

module rrep_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          ring_byte,
  input  logic                enabled,
  input  logic [12:0]         max_frame_len,
  output logic                full,
  output logic                cmd_valid,
  output rrep_pkg::cmd_t      cmd,
  input  logic                cmd_pop
);
  import rrep_pkg::*;

  phase_t      phase, phase_next;
  logic [12:0] cnt, cnt_next;
  logic [23:0] hdr, hdr_next;
  logic [12:0] flen, flen_next;
  logic [13:0] span, span_next;
  logic [2:0]  skip, skip_next;

  cmd_t             cq [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr, rd_ptr;
  logic [CQ_CW-1:0] count;

  logic        take;
  logic        emit;
  cmd_t        cmd_in;
  logic        push_cmd;
  logic [15:0] len;
  logic [15:0] span_full;
  logic        is_pending;
  logic        hdr_bad;
  logic        data_last;
  logic        skip_done;

  assign full      = (count == CQ_CW'(CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = cq[rd_ptr];
  assign take      = push && !full && enabled;
  assign push_cmd  = take && emit;

  assign len        = {ring_byte, hdr[23:16]};
  assign span_full  = (len + 16'd7) & ~16'd3;
  assign is_pending = (len == PENDING_LEN);
  assign hdr_bad    = !hdr[0] || (len < 16'(MIN_FRAME + CRC_BYTES)) ||
                      (17'(len) > 17'(max_frame_len) + 17'(CRC_BYTES));
  assign data_last  = (14'(cnt) + 14'd1) >= 14'(flen);
  assign skip_done  = (cnt[2:0] + 3'd1) == skip;

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    hdr_next   = hdr;
    flen_next  = flen;
    span_next  = span;
    skip_next  = skip;
    if (take) begin
      case (phase)
        PH_DATA: begin
          if (data_last) begin
            phase_next = PH_SKIP;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 13'd1;
          end
        end
        PH_SKIP: begin
          if (skip_done) begin
            phase_next = PH_HEADER;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 13'd1;
          end
        end
        default: begin
          phase_next = PH_HEADER;
          if (cnt[1:0] == 2'd3) begin
            cnt_next = '0;
            if (!is_pending && !hdr_bad) begin
              phase_next = PH_DATA;
              flen_next  = 13'(len - 16'(CRC_BYTES));
              span_next  = span_full[13:0];
              skip_next  = 3'(span_full - len);
            end
          end else begin
            hdr_next[8*cnt[1:0] +: 8] = ring_byte;
            cnt_next = {11'd0, cnt[1:0] + 2'd1};
          end
        end
      endcase
    end
  end

  always_comb begin
    emit        = 1'b0;
    cmd_in      = '0;
    cmd_in.kind = KIND_FRAME;
    case (phase)
      PH_DATA: begin
        emit        = 1'b1;
        cmd_in.kind = KIND_FRAME;
        cmd_in.data = ring_byte;
        cmd_in.last = data_last;
        cmd_in.flen = flen;
      end
      PH_SKIP: begin
        emit        = skip_done;
        cmd_in.kind = KIND_DONE;
        cmd_in.flen = flen;
        cmd_in.span = span;
      end
      default: begin
        emit        = (cnt[1:0] == 2'd3) && (is_pending || hdr_bad);
        cmd_in.kind = is_pending ? KIND_PENDING : KIND_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
    end
    hdr  <= hdr_next;
    flen <= flen_next;
    span <= span_next;
    skip <= skip_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_cmd) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_cmd && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push_cmd && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_cmd) begin
      cq[wr_ptr] <= cmd_in;
    end
  end

endmodule

>>> sv/rrep_back.sv
// Back part: read pointer, counters and the result queue.
`timescale 1ns / 1ps

module rrep_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  rrep_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           pop,
  output logic           empty,
  output rrep_pkg::res_t res
);
  import rrep_pkg::*;

  logic [PTR_W-1:0] rp, rp_next;
  logic [31:0]      packets, packets_next;
  logic [47:0]      bytes, bytes_next;
  logic [31:0]      errors, errors_next;
  logic [16:0]      rp_sum;

  res_t             rq [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr, rd_ptr;
  logic [RQ_CW-1:0] count;
  res_t             res_in;

  assign cmd_pop = cmd_valid && (count != RQ_CW'(RQ_DEPTH));
  assign empty   = (count == '0);
  assign res     = rq[rd_ptr];
  assign rp_sum  = 17'(rp) + 17'(cmd.span);

  always_comb begin
    rp_next      = rp;
    packets_next = packets;
    bytes_next   = bytes;
    errors_next  = errors;
    case (cmd.kind)
      KIND_DONE: begin
        packets_next = packets + 32'd1;
        bytes_next   = bytes + 48'(cmd.flen);
        rp_next      = rp_sum[PTR_W-1:0];
      end
      KIND_BAD: begin
        errors_next = errors + 32'd1;
        rp_next     = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_in               = '0;
    res_in.kind          = cmd.kind;
    res_in.next_read_ptr = 13'(rp_next);
    res_in.capr_value    = 16'(rp_next) - 16'(CAPR_OFFSET);
    res_in.packet_count  = packets_next;
    res_in.byte_count    = bytes_next;
    res_in.error_count   = errors_next;
    case (cmd.kind)
      KIND_FRAME: begin
        res_in.frame_byte   = cmd.data;
        res_in.last_byte    = cmd.last;
        res_in.frame_length = cmd.flen;
      end
      KIND_DONE: begin
        res_in.frame_length = cmd.flen;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp      <= '0;
      packets <= '0;
      bytes   <= '0;
      errors  <= '0;
    end else if (cmd_pop) begin
      rp      <= rp_next;
      packets <= packets_next;
      bytes   <= bytes_next;
      errors  <= errors_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (cmd_pop) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (cmd_pop && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!cmd_pop && pop && !empty) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rq[wr_ptr] <= res_in;
    end
  end

endmodule

>>> sv/rx_ring_entry_parser_top.sv
// Top level of the receive ring entry parser with its configuration registers.
//
//   Channel  Handshake            Payload
//   input    push / full          ring_byte
//   result   empty / pop          kind, frame_byte, last_byte, frame_length,
//                                 next_read_ptr, capr_value, packet_count,
//                                 byte_count, error_count
//   config   cfg_write            cfg_index, cfg_data
//
// One ring byte is taken every cycle while the receiver is enabled and the command queue has room.
// A result is written into the command queue when its byte is taken; the back part then
// moves the command into the result queue, whose head drives the result ports, together with the counter update.
// Reset is synchronous: it clears parsing state, pointer and counters,
// disables the receiver and sets the frame limit to 1514.
// A stalled result side fills the result queue, then the command queue,
// and only then raises full.
`timescale 1ns / 1ps

module rx_ring_entry_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ring_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  frame_byte,
  output logic        last_byte,
  output logic [12:0] frame_length,
  output logic [12:0] next_read_ptr,
  output logic [15:0] capr_value,
  output logic [31:0] packet_count,
  output logic [47:0] byte_count,
  output logic [31:0] error_count,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  import rrep_pkg::*;

  logic        enabled;
  logic [12:0] max_frame_len;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;
  res_t        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b0;
      max_frame_len <= MAX_FRAME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLED:       enabled       <= cfg_data[0];
        REG_MAX_FRAME_LEN: max_frame_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rrep_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .ring_byte     (ring_byte),
    .enabled       (enabled),
    .max_frame_len (max_frame_len),
    .full          (full),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  rrep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign kind          = res.kind;
  assign frame_byte    = res.frame_byte;
  assign last_byte     = res.last_byte;
  assign frame_length  = res.frame_length;
  assign next_read_ptr = res.next_read_ptr;
  assign capr_value    = res.capr_value;
  assign packet_count  = res.packet_count;
  assign byte_count    = res.byte_count;
  assign error_count   = res.error_count;

endmodule
